@@ src/tdec_pkg.sv @@
// Shared constants and field widths for the temperature drift equilibrium checker.
package tdec_pkg;

  localparam int TEMP_W = 24;
  localparam int TIME_W = 48;
  localparam int WIN_W  = 6;
  localparam int LIM_W  = 20;
  localparam int CFG_IDX_W = 1;

  // Span bit where the limit product splits, and the bound past which the check always passes.
  localparam int SPAN_SPLIT = 22;
  localparam int BIG_SPAN_BIT = 44;

  localparam logic signed [TEMP_W-1:0] TEMP_FLOOR = -24'sd102400;
  localparam logic [TIME_W-1:0] MIN_SPAN_US = 48'd100000;
  localparam logic [LIM_W-1:0]  US_PER_S    = 20'd1000000;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SAMPLES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIFT_LIMIT    = 1'b1;

endpackage

@@ src/tdec_ring.sv @@
// History ring: temperature and time memories, one write and one registered read port.
module tdec_ring
  import tdec_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int PTR_W = 6
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [PTR_W-1:0]         waddr_i,
  input  logic signed [TEMP_W-1:0] wtemp_i,
  input  logic [TIME_W-1:0]        wtime_i,
  input  logic                     re_i,
  input  logic [PTR_W-1:0]         raddr_i,
  output logic signed [TEMP_W-1:0] rtemp_o,
  output logic [TIME_W-1:0]        rtime_o
);

  logic signed [TEMP_W-1:0] temp_mem [DEPTH];
  logic [TIME_W-1:0]        time_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      temp_mem[waddr_i] <= wtemp_i;
      time_mem[waddr_i] <= wtime_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rtemp_o <= temp_mem[raddr_i];
      rtime_o <= time_mem[raddr_i];
    end
  end

endmodule

@@ src/temperature_drift_equilibrium_check.sv @@
// Pipeline: ring read at the accepting edge, then span and difference, products, final
//   compare into the output register; a stalled output holds every stage.
// Throughput: one sample per cycle unless the output stalls; the ring takes at most one write
//   and one read each cycle, and the limit-by-span product is split in two 20x22 partial products.
// Reset: pointer, fill count and pipeline valids clear at once and configuration returns to
//   its defaults; the history memories are not cleared and only affect a result once written.
module temperature_drift_equilibrium_check
  import tdec_pkg::*;
#(
  parameter int HISTORY_DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [LIM_W-1:0]         cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     sample_valid_i,
  input  logic signed [TEMP_W-1:0] temperature_i,
  input  logic [TIME_W-1:0]        timestamp_us_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     sample_stored_o,
  output logic [$clog2(HISTORY_DEPTH+1)-1:0] samples_held_o,
  output logic                     at_equilibrium_o
);

  localparam int PTR_W = $clog2(HISTORY_DEPTH);
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int SW    = ((PTR_W > WIN_W) ? PTR_W : WIN_W) + 1;
  localparam int LO_W  = SPAN_SPLIT;
  localparam int HI_W  = BIG_SPAN_BIT - SPAN_SPLIT;
  localparam int LHS_W = TEMP_W + LIM_W;

  typedef struct packed {
    logic                     stored;
    logic [CNT_W-1:0]         fill;
    logic                     chk;
    logic signed [TEMP_W-1:0] temp_new;
    logic [TIME_W-1:0]        time_new;
  } s1_t;

  typedef struct packed {
    logic                     stored;
    logic [CNT_W-1:0]         fill;
    logic                     chk;
    logic                     big;
    logic [BIG_SPAN_BIT-1:0]  dt;
    logic [TEMP_W-1:0]        dabs;
  } s2_t;

  typedef struct packed {
    logic                     stored;
    logic [CNT_W-1:0]         fill;
    logic                     chk;
    logic                     big;
    logic [LHS_W-1:0]         lhs;
    logic [LIM_W+LO_W-1:0]    plo;
    logic [LIM_W+HI_W-1:0]    phi;
  } s3_t;

  logic [WIN_W-1:0] window_q;
  logic [LIM_W-1:0] limit_q;
  logic [PTR_W-1:0] wp_q, wp_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic signed [TEMP_W-1:0] newest_temp_q;
  logic [TIME_W-1:0]        newest_time_q;

  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;
  s1_t s1_q, s1_d;
  s2_t s2_q, s2_d;
  s3_t s3_q, s3_d;
  logic stored_q, eq_q, eq_d;
  logic [CNT_W-1:0] held_q;

  logic accept, store;
  logic [PTR_W-1:0] newest_idx, old_idx;
  logic [SW-1:0] idx_diff;
  logic signed [TEMP_W-1:0] old_temp;
  logic [TIME_W-1:0]        old_time;
  logic [TIME_W-1:0]        span;
  logic signed [TEMP_W:0]   tdiff;
  logic [63:0]              rhs;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WIN_W'(30);
      limit_q  <= LIM_W'(10);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_WINDOW_SAMPLES: window_q <= cfg_data_i[WIN_W-1:0];
        CFG_DRIFT_LIMIT:    limit_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Each stage moves on when the one after it is empty or moving.
  assign en4 = !v4_q || out_ready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;
  assign accept = in_valid_i && en1;
  assign store  = accept && sample_valid_i && (temperature_i >= TEMP_FLOOR);

  always_comb begin
    wp_d   = wp_q;
    fill_d = fill_q;
    if (store) begin
      wp_d = (wp_q == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : wp_q + 1'b1;
      if (fill_q != CNT_W'(HISTORY_DEPTH)) begin
        fill_d = fill_q + 1'b1;
      end
    end
  end

  // Newest entry is the one being written, else the last one written.
  // Older slot index only matters when window < fill <= depth, so one wrap suffices.
  always_comb begin
    newest_idx = store ? wp_q
               : ((wp_q == '0) ? PTR_W'(HISTORY_DEPTH - 1) : wp_q - 1'b1);
    idx_diff = SW'(newest_idx) - SW'(window_q);
    old_idx  = idx_diff[SW-1] ? PTR_W'(idx_diff + SW'(HISTORY_DEPTH)) : PTR_W'(idx_diff);
  end

  always_comb begin
    s1_d.stored   = store;
    s1_d.fill     = fill_d;
    s1_d.chk      = (SW'(fill_d) > SW'(window_q)) && (window_q != '0) && (limit_q != '0);
    s1_d.temp_new = store ? temperature_i : newest_temp_q;
    s1_d.time_new = store ? timestamp_us_i : newest_time_q;
  end

  tdec_ring #(
    .DEPTH (HISTORY_DEPTH),
    .PTR_W (PTR_W)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (store),
    .waddr_i (wp_q),
    .wtemp_i (temperature_i),
    .wtime_i (timestamp_us_i),
    .re_i    (accept),
    .raddr_i (old_idx),
    .rtemp_o (old_temp),
    .rtime_o (old_time)
  );

  always_comb begin
    span  = s1_q.time_new - old_time;
    tdiff = {s1_q.temp_new[TEMP_W-1], s1_q.temp_new} - {old_temp[TEMP_W-1], old_temp};
    s2_d.stored = s1_q.stored;
    s2_d.fill   = s1_q.fill;
    s2_d.chk    = s1_q.chk && (s1_q.time_new >= old_time) && (span >= MIN_SPAN_US);
    s2_d.big    = (span[TIME_W-1:BIG_SPAN_BIT] != '0);
    s2_d.dt     = span[BIG_SPAN_BIT-1:0];
    s2_d.dabs   = tdiff[TEMP_W] ? TEMP_W'(-tdiff) : tdiff[TEMP_W-1:0];
  end

  always_comb begin
    s3_d.stored = s2_q.stored;
    s3_d.fill   = s2_q.fill;
    s3_d.chk    = s2_q.chk;
    s3_d.big    = s2_q.big;
    s3_d.lhs    = LHS_W'(s2_q.dabs) * LHS_W'(US_PER_S);
    s3_d.plo    = (LIM_W+LO_W)'(limit_q) * (LIM_W+LO_W)'(s2_q.dt[LO_W-1:0]);
    s3_d.phi    = (LIM_W+HI_W)'(limit_q) * (LIM_W+HI_W)'(s2_q.dt[BIG_SPAN_BIT-1:LO_W]);
  end

  always_comb begin
    rhs  = (64'(s3_q.phi) << LO_W) + 64'(s3_q.plo);
    eq_d = s3_q.chk && (s3_q.big || (64'(s3_q.lhs) < rhs));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      fill_q <= '0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
    end else begin
      wp_q   <= wp_d;
      fill_q <= fill_d;
      if (en1) v1_q <= accept;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store) begin
      newest_temp_q <= temperature_i;
      newest_time_q <= timestamp_us_i;
    end
    if (accept) s1_q <= s1_d;
    if (en2 && v1_q) s2_q <= s2_d;
    if (en3 && v2_q) s3_q <= s3_d;
    if (en4 && v3_q) begin
      stored_q <= s3_q.stored;
      held_q   <= s3_q.fill;
      eq_q     <= eq_d;
    end
  end

  assign out_valid_o      = v4_q;
  assign sample_stored_o  = stored_q;
  assign samples_held_o   = held_q;
  assign at_equilibrium_o = eq_q;

`ifndef SYNTHESIS
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (samples_held_o <= CNT_W'(HISTORY_DEPTH)))
    else $error("fill count past history depth");

  a_eq_needs_history: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && at_equilibrium_o) |-> (samples_held_o > window_q))
    else $error("equilibrium flagged without enough history");

  a_fill_only_on_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !store |=> $stable(fill_q) && $stable(wp_q))
    else $error("history pointer moved without a stored sample");

  a_stall_from_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled while output side free");
`endif

endmodule
